// ===== hw/rtl/ptc_pkg.sv =====
// ============================================================================
// ptc_pkg: shared types and constants for the planar trilateration core
// Payload structs, status codes and the fixed widths of the solver datapath.
// ============================================================================
package ptc_pkg;

    // Anchor count default and configuration index width
    localparam int NUM_ANCHORS_DEF = 4;
    localparam int CFG_IDX_W       = 3;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int RANGE_W  = 31;
    localparam int IDX_W    = 2;

    // Datapath widths: differences, squares, sums, split halves, products
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int RSQ_W    = 2 * RANGE_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int HALF_W   = SUM_W / 2;
    localparam int PH_W     = HALF_W + DIFF_W;
    localparam int PL_W     = HALF_W + 1 + DIFF_W;
    localparam int PROD_W   = 101;
    localparam int NUM_W    = PROD_W + 1;
    localparam int DEN_W    = SUM_W;

    // Divider: quotient bits and the largest offset that is still in range
    localparam int QBITS    = 42;
    localparam int Q_W      = QBITS;
    localparam int LIM_BIT  = 40;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_COLLINEAR  = 2'd2,
        ST_SATURATED  = 2'd3
    } ptc_status_t;

    typedef struct packed {
        logic [IDX_W-1:0]   first_anchor;
        logic [IDX_W-1:0]   second_anchor;
        logic [IDX_W-1:0]   third_anchor;
        logic [RANGE_W-1:0] range_first;
        logic [RANGE_W-1:0] range_second;
        logic [RANGE_W-1:0] range_third;
    } ptc_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] tag_x;
        logic signed [COORD_W-1:0] tag_y;
        ptc_status_t               status;
    } ptc_out_t;

    // Per-item sideband carried alongside the divider
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      coincident;
        logic                      collinear;
    } ptc_side_t;

    // Divider result for one coordinate
    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] quo;
    } ptc_quo_t;

endpackage

// ===== hw/rtl/ptc_div_pipe.sv =====
// ============================================================================
// ptc_div_pipe: pipelined restoring divider, two numerators, one divisor
// One quotient bit per stage, with an overflow precheck in front.
// ============================================================================
module ptc_div_pipe
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    input  ptc_side_t        side_in,
    output logic             out_valid,
    input  logic             out_ready,
    output ptc_quo_t         quo_x,
    output ptc_quo_t         quo_y,
    output ptc_side_t        side_out
);

    localparam int DIV_W = DEN_W + QBITS;

    logic             vld_reg   [QBITS+1];
    logic             en        [QBITS+2];
    logic [NUM_W-1:0] r_x_reg   [QBITS];
    logic [NUM_W-1:0] r_y_reg   [QBITS];
    logic [DEN_W-1:0] d_reg     [QBITS];
    logic [Q_W-1:0]   q_x_reg   [QBITS+1];
    logic [Q_W-1:0]   q_y_reg   [QBITS+1];
    logic             ovf_x_reg [QBITS+1];
    logic             ovf_y_reg [QBITS+1];
    ptc_side_t        side_reg  [QBITS+1];

    // Advance a stage when it is empty or the next one moves
    assign en[QBITS+1] = out_ready;
    for (genvar s = 0; s <= QBITS; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end
    assign in_ready = en[0];

    // Precheck: quotient must fit in QBITS bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_x_reg[0]   <= num_x;
            r_y_reg[0]   <= num_y;
            d_reg[0]     <= den;
            q_x_reg[0]   <= '0;
            q_y_reg[0]   <= '0;
            ovf_x_reg[0] <= DIV_W'(num_x) >= {den, {QBITS{1'b0}}};
            ovf_y_reg[0] <= DIV_W'(num_y) >= {den, {QBITS{1'b0}}};
            side_reg[0]  <= side_in;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= QBITS; k++) begin : g_stage
        localparam int BIT = QBITS - k;
        logic [DIV_W-1:0] dsh;
        logic             ge_x;
        logic             ge_y;

        always_comb
        begin
            dsh  = DIV_W'(d_reg[k-1]) << BIT;
            ge_x = DIV_W'(r_x_reg[k-1]) >= dsh;
            ge_y = DIV_W'(r_y_reg[k-1]) >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                q_x_reg[k]   <= q_x_reg[k-1] | (Q_W'(ge_x) << BIT);
                q_y_reg[k]   <= q_y_reg[k-1] | (Q_W'(ge_y) << BIT);
                ovf_x_reg[k] <= ovf_x_reg[k-1];
                ovf_y_reg[k] <= ovf_y_reg[k-1];
                side_reg[k]  <= side_reg[k-1];
            end
        end

        // Subtract the shifted divisor where it fits; the last stage keeps no remainder
        if (k < QBITS) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    r_x_reg[k] <= ge_x ? r_x_reg[k-1] - dsh[NUM_W-1:0] : r_x_reg[k-1];
                    r_y_reg[k] <= ge_y ? r_y_reg[k-1] - dsh[NUM_W-1:0] : r_y_reg[k-1];
                    d_reg[k]   <= d_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QBITS];
    assign quo_x     = '{ovf: ovf_x_reg[QBITS], quo: q_x_reg[QBITS]};
    assign quo_y     = '{ovf: ovf_y_reg[QBITS], quo: q_y_reg[QBITS]};
    assign side_out  = side_reg[QBITS];

endmodule

// ===== hw/rtl/planar_trilateration_core.sv =====
// ============================================================================
// planar_trilateration_core: 2D tag position from three anchor ranges
// Solves the trilateration system exactly in wide integers, one divisor.
// ============================================================================
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_ready | ptc_in_t  anchors + ranges
//  rsp     | out       | rsp_valid / rsp_ready | ptc_out_t tag x, y, status
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data anchors
//
//  One transaction per cycle while rsp_ready is high; 7 arithmetic stages,
//  43 divider stages (precheck, then a quotient bit each), output register.
//  Reset clears the anchor registers to zero and empties the pipeline.
//  Each stage advances when it is empty or its successor advances, so a
//  stalled output holds its result while empty stages upstream keep filling.
//
module planar_trilateration_core
    import ptc_pkg::*;
#(
    parameter int NUM_ANCHORS = NUM_ANCHORS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ptc_in_t              req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output ptc_out_t             rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int AIDX_W = $clog2(NUM_ANCHORS);
    localparam int NREG   = 2 * NUM_ANCHORS;
    localparam int ACC_W  = Q_W + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(COORD_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(COORD_MIN);
    localparam logic [Q_W-1:0]          Q_LIM   = Q_W'(1) << LIM_BIT;

    typedef struct packed {
        logic                      sat;
        logic signed [COORD_W-1:0] val;
    } coord_t;

    // Clamp anchor index to the last anchor
    function automatic logic [AIDX_W-1:0] pick(input logic [IDX_W-1:0] idx);
        if (idx > IDX_W'(NUM_ANCHORS - 1))
            return AIDX_W'(NUM_ANCHORS - 1);
        else
            return AIDX_W'(idx);
    endfunction

    // Base plus signed offset, saturated to the coordinate range
    function automatic coord_t fix_coord(input logic signed [COORD_W-1:0] base,
                                         input ptc_quo_t qd, input logic neg);
        logic signed [ACC_W-1:0] sum;
        coord_t                  res;
        sum = neg ? ACC_W'(base) - $signed(ACC_W'(qd.quo))
                  : ACC_W'(base) + $signed(ACC_W'(qd.quo));
        res.sat = 1'b0;
        res.val = sum[COORD_W-1:0];
        if (qd.ovf || qd.quo > Q_LIM)
        begin
            res.sat = 1'b1;
            res.val = neg ? COORD_MIN : COORD_MAX;
        end
        else if (sum > ACC_MAX)
        begin
            res.sat = 1'b1;
            res.val = COORD_MAX;
        end
        else if (sum < ACC_MIN)
        begin
            res.sat = 1'b1;
            res.val = COORD_MIN;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Anchor registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] anc_x_reg [NUM_ANCHORS];
    logic signed [COORD_W-1:0] anc_y_reg [NUM_ANCHORS];

    assign cfg_ready = 1'b1;

    // Write an anchor coordinate; drop indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ANCHORS; i++)
            begin
                anc_x_reg[i] <= '0;
                anc_y_reg[i] <= '0;
            end
        end
        else if (cfg_valid && {1'b0, cfg_index} < (CFG_IDX_W + 1)'(NREG))
        begin
            if (cfg_index[0])
                anc_y_reg[cfg_index[AIDX_W:1]] <= cfg_data;
            else
                anc_x_reg[cfg_index[AIDX_W:1]] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage enables
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en_o;
    logic div_ready;
    logic div_valid;

    assign en_o = !rsp_valid || rsp_ready;
    assign en7  = !v7_reg || div_ready;
    assign en6  = !v6_reg || en7;
    assign en5  = !v5_reg || en6;
    assign en4  = !v4_reg || en5;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign req_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= req_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: select anchors, offsets relative to A
    // ------------------------------------------------------------------
    logic [AIDX_W-1:0]         ia, ib, ic;
    logic signed [COORD_W-1:0] ax1_reg, ay1_reg;
    logic signed [DIFF_W-1:0]  bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic [RANGE_W-1:0]        ra1_reg, rb1_reg, rc1_reg;

    assign ia = pick(req_data.first_anchor);
    assign ib = pick(req_data.second_anchor);
    assign ic = pick(req_data.third_anchor);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax1_reg <= anc_x_reg[ia];
            ay1_reg <= anc_y_reg[ia];
            bx1_reg <= DIFF_W'(anc_x_reg[ib]) - DIFF_W'(anc_x_reg[ia]);
            by1_reg <= DIFF_W'(anc_y_reg[ib]) - DIFF_W'(anc_y_reg[ia]);
            cx1_reg <= DIFF_W'(anc_x_reg[ic]) - DIFF_W'(anc_x_reg[ia]);
            cy1_reg <= DIFF_W'(anc_y_reg[ic]) - DIFF_W'(anc_y_reg[ia]);
            ra1_reg <= req_data.range_first;
            rb1_reg <= req_data.range_second;
            rc1_reg <= req_data.range_third;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares and cross terms
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ax2_reg, ay2_reg;
    logic signed [DIFF_W-1:0]  bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [SQ_W-1:0]    bxx_reg, byy_reg, cxx_reg, cyy_reg, bxcy_reg, bycx_reg;
    logic [RSQ_W-1:0]          raa_reg, rbb_reg, rcc_reg;
    logic                      coin2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            bxx_reg   <= bx1_reg * bx1_reg;
            byy_reg   <= by1_reg * by1_reg;
            cxx_reg   <= cx1_reg * cx1_reg;
            cyy_reg   <= cy1_reg * cy1_reg;
            bxcy_reg  <= bx1_reg * cy1_reg;
            bycx_reg  <= by1_reg * cx1_reg;
            raa_reg   <= ra1_reg * ra1_reg;
            rbb_reg   <= rb1_reg * rb1_reg;
            rcc_reg   <= rc1_reg * rc1_reg;
            coin2_reg <= (bx1_reg == '0) && (by1_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: right-hand sides and cross product
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ax3_reg, ay3_reg;
    logic signed [DIFF_W-1:0]  bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [SUM_W-1:0]   p3_reg, v3v_reg, cross3_reg;
    logic                      coin3_reg;
    logic signed [SUM_W-1:0]   d2, c2;

    always_comb
    begin
        d2 = SUM_W'(bxx_reg) + SUM_W'(byy_reg);
        c2 = SUM_W'(cxx_reg) + SUM_W'(cyy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
            bx3_reg    <= bx2_reg;
            by3_reg    <= by2_reg;
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            p3_reg     <= $signed(SUM_W'(raa_reg)) - $signed(SUM_W'(rbb_reg)) + d2;
            v3v_reg    <= $signed(SUM_W'(raa_reg)) - $signed(SUM_W'(rcc_reg)) + c2;
            cross3_reg <= SUM_W'(bxcy_reg) - SUM_W'(bycx_reg);
            coin3_reg  <= coin2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of the numerators
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ax4_reg, ay4_reg;
    logic signed [PH_W-1:0]    pcy_h_reg, vby_h_reg, vbx_h_reg, pcx_h_reg;
    logic signed [PL_W-1:0]    pcy_l_reg, vby_l_reg, vbx_l_reg, pcx_l_reg;
    logic signed [DEN_W-1:0]   den4_reg;
    logic                      coin4_reg, coll4_reg;
    logic signed [HALF_W-1:0]  ph, vh;
    logic signed [HALF_W:0]    pl, vl;

    always_comb
    begin
        ph = $signed(p3_reg[SUM_W-1:HALF_W]);
        vh = $signed(v3v_reg[SUM_W-1:HALF_W]);
        pl = $signed({1'b0, p3_reg[HALF_W-1:0]});
        vl = $signed({1'b0, v3v_reg[HALF_W-1:0]});
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            pcy_h_reg <= ph * cy3_reg;
            vby_h_reg <= vh * by3_reg;
            vbx_h_reg <= vh * bx3_reg;
            pcx_h_reg <= ph * cx3_reg;
            pcy_l_reg <= pl * cy3_reg;
            vby_l_reg <= vl * by3_reg;
            vbx_l_reg <= vl * bx3_reg;
            pcx_l_reg <= pl * cx3_reg;
            den4_reg  <= cross3_reg <<< 1;
            coin4_reg <= coin3_reg;
            coll4_reg <= cross3_reg == '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: full products
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ax5_reg, ay5_reg;
    logic signed [PROD_W-1:0]  pcy5_reg, vby5_reg, vbx5_reg, pcx5_reg;
    logic signed [DEN_W-1:0]   den5_reg;
    logic                      coin5_reg, coll5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            pcy5_reg  <= (PROD_W'(pcy_h_reg) <<< HALF_W) + PROD_W'(pcy_l_reg);
            vby5_reg  <= (PROD_W'(vby_h_reg) <<< HALF_W) + PROD_W'(vby_l_reg);
            vbx5_reg  <= (PROD_W'(vbx_h_reg) <<< HALF_W) + PROD_W'(vbx_l_reg);
            pcx5_reg  <= (PROD_W'(pcx_h_reg) <<< HALF_W) + PROD_W'(pcx_l_reg);
            den5_reg  <= den4_reg;
            coin5_reg <= coin4_reg;
            coll5_reg <= coll4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: numerators
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ax6_reg, ay6_reg;
    logic signed [NUM_W-1:0]   nx6_reg, ny6_reg;
    logic signed [DEN_W-1:0]   den6_reg;
    logic                      coin6_reg, coll6_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
            nx6_reg   <= NUM_W'(pcy5_reg) - NUM_W'(vby5_reg);
            ny6_reg   <= NUM_W'(vbx5_reg) - NUM_W'(pcx5_reg);
            den6_reg  <= den5_reg;
            coin6_reg <= coin5_reg;
            coll6_reg <= coll5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: magnitudes and quotient signs
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] nx7_reg, ny7_reg;
    logic [DEN_W-1:0] den7_reg;
    ptc_side_t        side7_reg;

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            nx7_reg  <= nx6_reg[NUM_W-1] ? NUM_W'(-nx6_reg) : NUM_W'(nx6_reg);
            ny7_reg  <= ny6_reg[NUM_W-1] ? NUM_W'(-ny6_reg) : NUM_W'(ny6_reg);
            den7_reg <= den6_reg[DEN_W-1] ? DEN_W'(-den6_reg) : DEN_W'(den6_reg);
            side7_reg <= '{base_x:     ax6_reg,
                           base_y:     ay6_reg,
                           neg_x:      nx6_reg[NUM_W-1] ^ den6_reg[DEN_W-1],
                           neg_y:      ny6_reg[NUM_W-1] ^ den6_reg[DEN_W-1],
                           coincident: coin6_reg,
                           collinear:  coll6_reg};
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    ptc_quo_t  quo_x, quo_y;
    ptc_side_t side_d;

    ptc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .in_ready  (div_ready),
        .num_x     (nx7_reg),
        .num_y     (ny7_reg),
        .den       (den7_reg),
        .side_in   (side7_reg),
        .out_valid (div_valid),
        .out_ready (en_o),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .side_out  (side_d)
    );

    // ------------------------------------------------------------------
    // Output register: offset, clamp, status
    // ------------------------------------------------------------------
    logic     rsp_valid_reg;
    ptc_out_t rsp_data_reg, rsp_data_next;
    coord_t   cx_res, cy_res;

    always_comb
    begin
        cx_res = fix_coord(side_d.base_x, quo_x, side_d.neg_x);
        cy_res = fix_coord(side_d.base_y, quo_y, side_d.neg_y);
        rsp_data_next.tag_x  = '0;
        rsp_data_next.tag_y  = '0;
        if (side_d.coincident)
            rsp_data_next.status = ST_COINCIDENT;
        else if (side_d.collinear)
            rsp_data_next.status = ST_COLLINEAR;
        else
        begin
            rsp_data_next.tag_x  = cx_res.val;
            rsp_data_next.tag_y  = cy_res.val;
            rsp_data_next.status = (cx_res.sat || cy_res.sat) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en_o)
        begin
            rsp_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== hw/rtl/ptc_checker.sv =====
// ============================================================================
// ptc_checker: port-level checks for the planar trilateration core
// Output hold, idle acceptance and status-to-coordinate consistency.
// ============================================================================
module ptc_checker
    import ptc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input ptc_out_t rsp_data
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    // Accept input whenever no result waits
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input blocked with empty output");

    // Degenerate geometry reports a zero position
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_COINCIDENT ||
                      rsp_data.status == ST_COLLINEAR)
        |-> rsp_data.tag_x == '0 && rsp_data.tag_y == '0)
        else $error("degenerate status with nonzero position");

    // Saturation leaves a coordinate at a range limit
    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_SATURATED
        |-> rsp_data.tag_x == COORD_MAX || rsp_data.tag_x == COORD_MIN ||
            rsp_data.tag_y == COORD_MAX || rsp_data.tag_y == COORD_MIN)
        else $error("saturated status without clamped coordinate");

endmodule

bind planar_trilateration_core ptc_checker u_ptc_checker (.*);
